[design/rts_pkg.sv]
// ----------------------------------------------------------------------------
// rts_pkg
// shared types and constants for the rgba8 to rgb5a3 tile swizzler
// ----------------------------------------------------------------------------
package rts_pkg;

  localparam int TEXEL_WIDTH   = 16;
  localparam int PIXEL_WIDTH   = 32;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CFG_WIDTH     = 11;
  localparam int STRIPE_WIDTH  = 9;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [CFG_WIDTH-1:0] MIN_DIM = 11'd4;

  typedef struct packed {
    logic                   req_type;
    logic [PIXEL_WIDTH-1:0] pixel;
  } rts_in_t;

  typedef struct packed {
    logic [TEXEL_WIDTH-1:0] texel;
    logic                   end_of_image;
  } rts_out_t;

  // stripe hand-off from fill side to drain side
  typedef struct packed {
    logic start;
    logic is_final;
  } rts_stripe_t;

endpackage

[design/rts_ram.sv]
// ----------------------------------------------------------------------------
// rts_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/rts_fill.sv]
// ----------------------------------------------------------------------------
// rts_fill
// pixel to rgb5a3 conversion and raster fill of the ping-pong stripe store
// ----------------------------------------------------------------------------
module rts_fill import rts_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  logic [PIXEL_WIDTH-1:0]              pixel,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_width,
  input  logic [CFG_WIDTH-1:0]                image_height,
  output logic                                wr_en,
  output logic [$clog2(8*MAX_WIDTH)-1:0]      wr_addr,
  output logic [TEXEL_WIDTH-1:0]              wr_data,
  output logic                                fill_bank,
  output rts_stripe_t                         stripe
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(8 * MAX_WIDTH);

  function automatic logic [TEXEL_WIDTH-1:0] to_rgb5a3(input logic [PIXEL_WIDTH-1:0] p);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    r = p[7:0];
    g = p[15:8];
    b = p[23:16];
    a = p[31:24];
    if (a[7:5] == 3'b111) begin
      to_rgb5a3 = {1'b1, r[7:3], g[7:3], b[7:3]};
    end else begin
      to_rgb5a3 = {1'b0, a[7:5], r[7:4], g[7:4], b[7:4]};
    end
  endfunction

  logic [CW-1:0]           col_r, col_nxt;
  logic [1:0]              row_r, row_nxt;
  logic [STRIPE_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                    bank_r, bank_nxt;

  logic [CFG_WIDTH-1:0]    eff_h;
  logic [STRIPE_WIDTH-1:0] th;
  logic [1:0]              tail;
  logic [WW-1:0]           tw4;
  logic [WW-1:0]           col_ext;
  logic [2:0]              row_inc;
  logic [STRIPE_WIDTH-1:0] cnt_inc;
  logic                    in_stripes;

  always_comb begin
    eff_h      = (image_height < MIN_DIM) ? MIN_DIM : image_height;
    th         = eff_h[CFG_WIDTH-1:2];
    tail       = eff_h[1:0];
    tw4        = eff_width & ~WW'(3);
    col_ext    = WW'(col_r);
    row_inc    = {1'b0, row_r} + 3'd1;
    cnt_inc    = cnt_r + STRIPE_WIDTH'(1);
    in_stripes = cnt_r < th;
  end

  assign wr_en   = fire && in_stripes && (col_ext < tw4);
  assign wr_addr = AW'(bank_r) * AW'(4 * MAX_WIDTH) + AW'(row_r) * AW'(MAX_WIDTH) + AW'(col_r);
  assign wr_data = to_rgb5a3(pixel);

  always_comb begin
    col_nxt         = col_r;
    row_nxt         = row_r;
    cnt_nxt         = cnt_r;
    bank_nxt        = bank_r;
    stripe.start    = 1'b0;
    stripe.is_final = 1'b0;
    if (fire) begin
      if (col_ext + WW'(1) >= eff_width) begin
        col_nxt = '0;
        if (in_stripes) begin
          if (row_r == 2'd3) begin
            row_nxt         = 2'd0;
            stripe.start    = 1'b1;
            stripe.is_final = (cnt_inc == th);
            bank_nxt        = ~bank_r;
            cnt_nxt         = cnt_inc;
            if (cnt_inc == th && tail == 2'd0) begin
              cnt_nxt = '0;
            end
          end else begin
            row_nxt = row_r + 2'd1;
          end
        end else begin
          // bottom rows below the last full stripe
          if (row_inc >= {1'b0, tail}) begin
            row_nxt = 2'd0;
            cnt_nxt = '0;
          end else begin
            row_nxt = row_inc[1:0];
          end
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cnt_r  <= '0;
      bank_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cnt_r  <= cnt_nxt;
      bank_r <= bank_nxt;
    end
  end

  assign fill_bank = bank_r;

endmodule

[design/rts_drain.sv]
// ----------------------------------------------------------------------------
// rts_drain
// tile order read sequencer for the completed stripe bank
// ----------------------------------------------------------------------------
module rts_drain import rts_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_width,
  input  logic                           fill_bank,
  input  rts_stripe_t                    stripe,
  output logic                           rd_en,
  output logic [$clog2(8*MAX_WIDTH)-1:0] rd_addr,
  output logic                           res_valid,
  output logic                           res_eoi
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int DW = $clog2(4 * MAX_WIDTH);
  localparam int LW = DW + 1;
  localparam int AW = $clog2(8 * MAX_WIDTH);

  logic [DW-1:0] idx_r, idx_nxt;
  logic          pending_r, pending_nxt;
  logic          final_r, final_nxt;

  logic [WW-1:0] tw4;
  logic [LW-1:0] len;
  logic [LW-1:0] idx_ext;
  logic [LW-1:0] idx_inc;
  logic          has_texel;

  always_comb begin
    tw4       = eff_width & ~WW'(3);
    len       = LW'(tw4) << 2;
    idx_ext   = LW'(idx_r);
    idx_inc   = idx_ext + LW'(1);
    has_texel = pending_r && (idx_ext < len);
  end

  // tile column, row within tile, texel within row
  assign rd_addr   = AW'(!fill_bank) * AW'(4 * MAX_WIDTH)
                   + AW'(idx_r[3:2]) * AW'(MAX_WIDTH)
                   + AW'((idx_r >> 4) << 2) + AW'(idx_r[1:0]);
  assign rd_en     = fire && has_texel;
  assign res_valid = fire && has_texel;
  assign res_eoi   = final_r && (idx_inc == len);

  always_comb begin
    idx_nxt     = idx_r;
    pending_nxt = pending_r;
    final_nxt   = final_r;
    if (fire && pending_r) begin
      if (!has_texel) begin
        pending_nxt = 1'b0;
      end else begin
        idx_nxt = idx_inc[DW-1:0];
        if (idx_inc >= len) begin
          pending_nxt = 1'b0;
        end
      end
    end
    if (stripe.start) begin
      pending_nxt = 1'b1;
      idx_nxt     = '0;
      final_nxt   = stripe.is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      pending_r <= 1'b0;
      final_r   <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      pending_r <= pending_nxt;
      final_r   <= final_nxt;
    end
  end

endmodule

[design/rgba_to_rgb5a3_tile_swizzle_top.sv]
// ----------------------------------------------------------------------------
// rgba_to_rgb5a3_tile_swizzle_top
// raster rgba8 pixels in, rgb5a3 texels out in 4x4 tile order
//
//   port group | dir    | handshake        | payload
//   in_        | input  | in_valid/stall   | rts_in_t  (req_type, pixel)
//   out_       | output | out_valid/stall  | rts_out_t (texel, end_of_image)
//   cfg_       | input  | cfg_valid/ready  | cfg_index, cfg_data
//
// one input transaction per clock while in_stall is low; a result passes
// through the registered read port of the stripe ram and then the output
// register. the stripe ram needs no clearing pass, so the block takes input
// right after reset. a stalled output holds the result; the input stalls
// only when both the ram read stage and the output register are full.
// ----------------------------------------------------------------------------
module rgba_to_rgb5a3_tile_swizzle_top import rts_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  rts_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output rts_out_t                 out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = 8 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  logic [CFG_WIDTH-1:0] image_width_r, image_width_nxt;
  logic [CFG_WIDTH-1:0] image_height_r, image_height_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_eoi_r, s1_eoi_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rts_out_t             out_data_r, out_data_nxt;

  logic [WW-1:0]          eff_width;
  logic                   accept;
  logic                   out_adv;
  logic                   fill_fire;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [TEXEL_WIDTH-1:0] wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [TEXEL_WIDTH-1:0] rd_data;
  logic                   fill_bank;
  rts_stripe_t            stripe;
  logic                   res_valid;
  logic                   res_eoi;

  // configuration
  assign cfg_ready = 1'b1;

  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width_nxt = cfg_data;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height_nxt = cfg_data;
      end
    end
  end

  // width clamped to 4..MAX_WIDTH
  always_comb begin
    if (image_width_r < MIN_DIM) begin
      eff_width = WW'(4);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(image_width_r);
    end
  end

  // handshake
  assign out_adv   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_adv;
  assign accept    = in_valid && !in_stall;
  assign fill_fire = accept && (in_data.req_type == REQ_PIXEL);

  rts_fill #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_fill (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fill_fire),
    .pixel        (in_data.pixel),
    .eff_width    (eff_width),
    .image_height (image_height_r),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .fill_bank    (fill_bank),
    .stripe       (stripe)
  );

  rts_drain #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (accept),
    .eff_width (eff_width),
    .fill_bank (fill_bank),
    .stripe    (stripe),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .res_valid (res_valid),
    .res_eoi   (res_eoi)
  );

  rts_ram #(
    .WIDTH (TEXEL_WIDTH),
    .DEPTH (DEPTH)
  ) u_stripe_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ram read stage and output register
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_eoi_nxt    = s1_eoi_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      s1_valid_nxt = res_valid;
      s1_eoi_nxt   = res_eoi;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_data_nxt.texel        = rd_data;
        out_data_nxt.end_of_image = s1_eoi_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= MIN_DIM;
      image_height_r <= MIN_DIM;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_eoi_r   <= s1_eoi_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[bench/tb_rgba_to_rgb5a3_tile_swizzle_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgba_to_rgb5a3_tile_swizzle_top
// self-checking bench for the rgba8 to rgb5a3 4x4 tile swizzler
//
// pixels and flush ticks go in through the stalled input channel while a
// shadow copy of the stripe buffers, fill counters and drain pointer works
// out the texel and end-of-image flag each transaction should produce. a
// checker pops that list on every output transaction. directed images cover
// the alpha threshold, color extremes, size clamping, tail rows and a tall
// image cut short; random images of small size follow, some with flush
// ticks mixed in and with sizes changed part way through. both sides idle
// and stall in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_rgba_to_rgb5a3_tile_swizzle_top;
  import rts_pkg::*;

  localparam int MAX_W          = 1024;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PIXELS  = 150;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  rts_in_t                  in_data;
  logic                     out_valid;
  logic                     out_stall;
  rts_out_t                 out_data;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]     cfg_data;

  // shadow of the block state
  logic [TEXEL_WIDTH-1:0] stripe_mem [0:8*MAX_W-1];
  logic [CFG_WIDTH-1:0]   width_reg;
  logic [CFG_WIDTH-1:0]   height_reg;
  int unsigned            fill_col;
  int unsigned            fill_row;
  int unsigned            stripe_cnt;
  logic                   fill_bank;
  logic [11:0]            drain_idx;
  logic                   drain_pending;
  logic                   drain_final;

  rts_out_t expected_texels [$];
  int       mismatch_count;
  int       pixels_sent;
  int       stuck_cycles;
  bit       calm;

  rgba_to_rgb5a3_tile_swizzle_top #(.MAX_WIDTH(MAX_W)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [TEXEL_WIDTH-1:0] rgb5a3_of(input logic [PIXEL_WIDTH-1:0] p);
    logic [7:0] a, b, g, r;
    {a, b, g, r} = p;
    if (a[7:5] == 3'b111) return {1'b1, r[7:3], g[7:3], b[7:3]};
    return {1'b0, a[7:5], r[7:4], g[7:4], b[7:4]};
  endfunction

  task automatic swizzle_predict(input rts_in_t item);
    int unsigned w, h, tw, th, tail, len, d, col, row;
    rts_out_t    res;
    w    = (width_reg < 4) ? 4 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h    = (height_reg < 4) ? 4 : height_reg;
    tw   = w >> 2;
    th   = h >> 2;
    tail = h & 3;
    if (drain_pending) begin
      len = 16 * tw;
      d   = drain_idx;
      if (d >= len) begin
        drain_pending = 1'b0;
      end else begin
        col = ((d >> 4) << 2) + (d & 3);
        row = (d >> 2) & 3;
        res.texel        = stripe_mem[(!fill_bank) * 4 * MAX_W + row * MAX_W + col];
        res.end_of_image = drain_final && (d + 1 == len);
        expected_texels.push_back(res);
        drain_idx = 12'(d + 1);
        if (d + 1 >= len) drain_pending = 1'b0;
      end
    end
    if (item.req_type == REQ_PIXEL) begin
      col = fill_col;
      if (stripe_cnt < th && col < 4 * tw)
        stripe_mem[fill_bank * 4 * MAX_W + (fill_row & 3) * MAX_W + col] = rgb5a3_of(item.pixel);
      if (col + 1 >= w) begin
        fill_col = 0;
        if (stripe_cnt < th) begin
          if (fill_row >= 3) begin
            fill_row      = 0;
            drain_pending = 1'b1;
            drain_idx     = '0;
            drain_final   = (stripe_cnt + 1 == th);
            fill_bank     = !fill_bank;
            stripe_cnt++;
            if (stripe_cnt == th && tail == 0) stripe_cnt = 0;
          end else begin
            fill_row++;
          end
        end else begin
          fill_row++;
          if (fill_row >= tail) begin
            fill_row   = 0;
            stripe_cnt = 0;
          end
        end
      end else begin
        fill_col = col + 1;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input logic req, input logic [PIXEL_WIDTH-1:0] pix);
    rts_in_t item;
    item.req_type = req;
    item.pixel    = pix;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    swizzle_predict(item);
    if (req == REQ_PIXEL) pixels_sent++;
    if (!calm && $urandom_range(0, 99) < 12) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg  = value;
      REG_IMAGE_HEIGHT: height_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(REG_IMAGE_WIDTH, CFG_WIDTH'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_WIDTH'(h));
  endtask

  function automatic int pick_width();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return $urandom_range(0, 3);
    if (sel < 85) return $urandom_range(4, 16);
    return $urandom_range(17, 32);
  endfunction

  function automatic int pick_height();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
  endfunction

  task automatic drain_stripe();
    while (drain_pending) send_item(REQ_FLUSH, $urandom);
  endtask

  // runs pixels until the fill side is back at the top left of an image
  task automatic send_image(input int flush_pct, input int pause_pct, input bit reshape);
    int sent;
    int cut;
    sent = 0;
    cut  = reshape ? $urandom_range(1, 60) : -1;
    do begin
      if ($urandom_range(0, 99) < flush_pct) begin
        send_item(REQ_FLUSH, $urandom);
      end else begin
        send_item(REQ_PIXEL, $urandom);
        sent++;
      end
      if (sent == cut) begin
        // width only changes on a stripe boundary with the drain finished
        if (fill_col == 0 && fill_row == 0) begin
          drain_stripe();
          set_size(pick_width(), pick_height());
        end else begin
          set_size(width_reg, pick_height());
        end
        cut = -1;
      end
      if ($urandom_range(0, 99) < pause_pct) wait_idle();
    end while (sent == 0 || fill_col != 0 || fill_row != 0 || stripe_cnt != 0);
  endtask

  task automatic test_texel_formats();
    logic [PIXEL_WIDTH-1:0] pix [16];
    pix = '{32'hFFFFFFFF, 32'h00000000, 32'hE0000000, 32'hDFFFFFFF,
            32'hE0F8F8F8, 32'hE0070707, 32'hC0F0F0F0, 32'h200F0F0F,
            32'hAA55AA55, 32'h55AA55AA, 32'hFF123456, 32'h7F89ABCD,
            32'h80FF0000, 32'hFF00FF00, 32'h1F0000FF, 32'h60A5C3E1};
    set_size(4, 4);
    foreach (pix[i]) send_item(REQ_PIXEL, pix[i]);
    drain_stripe();
    // flush tick with nothing left to drain
    send_item(REQ_FLUSH, 32'hFFFFFFFF);
  endtask

  task automatic test_size_clamps();
    set_size(0, 0);
    send_image(0, 0, 1'b0);
    drain_stripe();
    set_size(3, 3);
    write_reg(REG_UNUSED, 11'h7FF);
    send_image(10, 0, 1'b0);
    drain_stripe();
    set_size(8, 6);
    send_image(0, 0, 1'b0);
    send_image(0, 0, 1'b0);
    drain_stripe();
  endtask

  task automatic test_tall_image();
    set_size(4, 2047);
    repeat (32) send_item(REQ_PIXEL, $urandom);
    drain_stripe();
    // height drops below the stripes already filled
    set_size(4, 4);
    send_image(0, 0, 1'b0);
    send_image(0, 0, 1'b0);
    drain_stripe();
  endtask

  task automatic test_pause_pending();
    set_size(12, 8);
    send_image(5, 5, 1'b0);
    drain_stripe();
  endtask

  task automatic test_random_images();
    int start;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if (drain_pending) set_size(width_reg, pick_height());
      else set_size(pick_width(), pick_height());
      send_image($urandom_range(0, 15), 1, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) drain_stripe();
    end
    drain_stripe();
  endtask

  task automatic test_steady_stream();
    set_size(8, 8);
    calm = 1'b1;
    send_image(0, 0, 1'b0);
    drain_stripe();
  endtask

  initial begin : out_stall_gen
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < 5) begin
        repeat ($urandom_range(30, 80)) @(negedge clk);
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_texels
    rts_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_texels.size() == 0) begin
        $error("unexpected transaction: texel actual %h", out_data.texel);
        mismatch_count++;
      end else begin
        want = expected_texels.pop_front();
        if (out_data.texel !== want.texel) begin
          $error("texel expected %h actual %h", want.texel, out_data.texel);
          mismatch_count++;
        end
        if (out_data.end_of_image !== want.end_of_image) begin
          $error("end_of_image expected %b actual %b", want.end_of_image,
                 out_data.end_of_image);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_IMAGE_WIDTH;
    cfg_data       = '0;
    width_reg      = MIN_DIM;
    height_reg     = MIN_DIM;
    fill_col       = 0;
    fill_row       = 0;
    stripe_cnt     = 0;
    fill_bank      = 1'b0;
    drain_idx      = '0;
    drain_pending  = 1'b0;
    drain_final    = 1'b0;
    mismatch_count = 0;
    pixels_sent    = 0;
    stuck_cycles   = 0;
    calm           = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_texel_formats();
    test_size_clamps();
    test_tall_image();
    test_pause_pending();
    test_random_images();
    test_steady_stream();

    wait_idle();
    if (mismatch_count == 0 && expected_texels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
design/rts_pkg.sv
design/rts_ram.sv
design/rts_fill.sv
design/rts_drain.sv
design/rgba_to_rgb5a3_tile_swizzle_top.sv
bench/tb_rgba_to_rgb5a3_tile_swizzle_top.sv
